// ===== rtl/core/chunked_transfer_receiver_defines.svh =====
// Assertion macros shared by the receiver
`ifndef CHUNKED_TRANSFER_RECEIVER_DEFINES_SVH
`define CHUNKED_TRANSFER_RECEIVER_DEFINES_SVH

// Implication checked on every rising clock edge outside reset
`define CTR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent
`define CTR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ctr_pkg.sv =====
package ctr_pkg;

    // Request types
    localparam logic [1:0] REQ_BYTE   = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_CANCEL = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    // Status codes
    localparam logic [3:0] ST_LINK        = 4'd0;
    localparam logic [3:0] ST_HEADER_DONE = 4'd1;
    localparam logic [3:0] ST_CHUNK_OK    = 4'd2;
    localparam logic [3:0] ST_CHUNK_FAIL  = 4'd3;
    localparam logic [3:0] ST_FILE_DONE   = 4'd4;
    localparam logic [3:0] ST_CLOSED      = 4'd5;
    localparam logic [3:0] ST_CANCEL      = 4'd6;
    localparam logic [3:0] ST_HUNT_TMO    = 4'd7;
    localparam logic [3:0] ST_HEADER_TMO  = 4'd8;
    localparam logic [3:0] ST_CHUNK_TMO   = 4'd9;
    localparam logic [3:0] ST_TOO_LONG    = 4'd10;
    localparam logic [3:0] ST_SIZE_ERR    = 4'd11;

    // Configuration register indexes
    localparam logic [1:0] CFG_TIMEOUT   = 2'd0;
    localparam logic [1:0] CFG_CRC_EN    = 2'd1;
    localparam logic [1:0] CFG_MAX_CHUNK = 2'd2;

    localparam logic [23:0] TIMEOUT_RESET   = 24'd12000;
    localparam logic [23:0] MAX_CHUNK_RESET = 24'd32768;
    localparam logic [23:0] HEADER_HALF     = 24'd36;
    localparam logic [23:0] HEADER_BYTES    = 24'd72;
    localparam logic [31:0] CRC_POLY        = 32'hEDB88320;

    // Four-letter replies
    typedef enum logic [2:0] {
        WORD_LINK,
        WORD_EXIT,
        WORD_DONE,
        WORD_PASS,
        WORD_FAIL
    } word_t;

    // One single result
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [3:0]  code;
        logic [31:0] value;
    } item_t;

    // Results caused by one transaction: reply word, then item a, then item b
    typedef struct packed {
        logic  word_en;
        word_t word;
        logic  a_en;
        item_t a;
        logic  b_en;
        item_t b;
    } desc_t;

    function automatic logic [7:0] word_byte(word_t w, logic [1:0] i);
        logic [31:0] s;
        case (w)
            WORD_LINK: s = "LINK";
            WORD_EXIT: s = "EXIT";
            WORD_DONE: s = "DONE";
            WORD_PASS: s = "PASS";
            WORD_FAIL: s = "FAIL";
            default:   s = 32'd0;
        endcase
        word_byte = s[8*(3-i) +: 8];
    endfunction

    function automatic logic [7:0] mark_start(logic [2:0] p);
        logic [63:0] s;
        s = "RSTX7650";
        mark_start = s[8*(7-p) +: 8];
    endfunction

    function automatic logic [7:0] mark_close(logic [2:0] p);
        logic [63:0] s;
        s = "RSTXDONE";
        mark_close = s[8*(7-p) +: 8];
    endfunction

    // Bytewise reflected CRC-32 update
    function automatic logic [31:0] crc_byte(logic [31:0] c_in, logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        crc_byte = c;
    endfunction

endpackage

// ===== rtl/core/ctr_core.sv =====
module ctr_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_fire,
    input  logic [1:0]          req_type,
    input  logic [7:0]          rx_byte,
    output logic                desc_any,
    output ctr_pkg::desc_t      desc
);

    typedef enum logic [2:0] {
        PH_HUNT, PH_HEADER, PH_LEN, PH_PAYLOAD, PH_CRC, PH_HALT
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  pos_reg, pos_next;
    logic [23:0] count_reg, count_next;
    logic [23:0] timer_reg, timer_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] size_reg, size_next;
    logic [23:0] clen_reg, clen_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] crcc_reg, crcc_next;
    logic [31:0] crcr_reg, crcr_next;
    logic [23:0] tmo_reg;
    logic        crcen_reg;
    logic [23:0] maxc_reg;

    logic [23:0] cnt_inc;
    logic [31:0] shifted;
    logic [31:0] crc_fin;

    assign cnt_inc = count_reg + 24'd1;
    assign shifted = {shift_reg[23:0], rx_byte};
    assign crc_fin = ~crcr_reg;
    assign desc_any = desc.word_en | desc.a_en | desc.b_en;

    // Next state and results of the current transaction
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        timer_next = timer_reg;
        shift_next = shift_reg;
        size_next  = size_reg;
        clen_next  = clen_reg;
        total_next = total_reg;
        crcc_next  = crcc_reg;
        crcr_next  = crcr_reg;
        desc       = '0;
        desc.word  = ctr_pkg::WORD_EXIT;
        desc.b.kind = ctr_pkg::KIND_STATUS;

        if (phase_reg != PH_HALT) begin
            if (req_type == ctr_pkg::REQ_CANCEL) begin
                desc.word_en = 1'b1;
                desc.b_en    = 1'b1;
                desc.b.code  = ctr_pkg::ST_CANCEL;
                phase_next   = PH_HALT;
            end else if (req_type == ctr_pkg::REQ_TICK) begin
                timer_next = timer_reg + 24'd1;
                if (timer_next >= tmo_reg) begin
                    desc.word_en = 1'b1;
                    desc.b_en    = 1'b1;
                    desc.b.code  = (phase_reg == PH_HUNT) ? ctr_pkg::ST_HUNT_TMO :
                                   (phase_reg == PH_HEADER) ? ctr_pkg::ST_HEADER_TMO :
                                   ctr_pkg::ST_CHUNK_TMO;
                    phase_next   = PH_HALT;
                end
            end else if (req_type == ctr_pkg::REQ_BYTE) begin
                unique case (phase_reg)
                    PH_HUNT: begin
                        if (rx_byte == ctr_pkg::mark_start(pos_reg) ||
                            rx_byte == ctr_pkg::mark_close(pos_reg)) begin
                            if (pos_reg == 3'd7) begin
                                desc.b_en = 1'b1;
                                pos_next  = 3'd0;
                                if (rx_byte == ctr_pkg::mark_start(3'd7)) begin
                                    desc.word_en = 1'b1;
                                    desc.word    = ctr_pkg::WORD_LINK;
                                    desc.b.code  = ctr_pkg::ST_LINK;
                                    phase_next   = PH_HEADER;
                                    count_next   = '0;
                                    shift_next   = '0;
                                    timer_next   = '0;
                                end else begin
                                    desc.b.code = ctr_pkg::ST_CLOSED;
                                    phase_next  = PH_HALT;
                                end
                            end else begin
                                pos_next = pos_reg + 3'd1;
                            end
                        end else begin
                            pos_next = 3'd0;
                        end
                    end
                    PH_HEADER: begin
                        desc.a_en   = 1'b1;
                        desc.a.kind = ctr_pkg::KIND_HEADER;
                        desc.a.data = rx_byte;
                        if (count_reg < 24'd4) shift_next = shifted;
                        count_next = cnt_inc;
                        if (cnt_inc == ctr_pkg::HEADER_HALF) timer_next = '0;
                        if (cnt_inc >= ctr_pkg::HEADER_BYTES) begin
                            size_next    = shift_next;
                            total_next   = '0;
                            crcc_next    = '0;
                            crcr_next    = '1;
                            phase_next   = PH_LEN;
                            count_next   = '0;
                            shift_next   = '0;
                            timer_next   = '0;
                            desc.b_en    = 1'b1;
                            desc.b.code  = ctr_pkg::ST_HEADER_DONE;
                            desc.b.value = size_next;
                        end
                    end
                    PH_LEN: begin
                        shift_next = shifted;
                        count_next = cnt_inc;
                        if (cnt_inc >= 24'd4) begin
                            count_next = '0;
                            shift_next = '0;
                            timer_next = '0;
                            if (shifted >= {8'd0, maxc_reg}) begin
                                desc.word_en = 1'b1;
                                desc.b_en    = 1'b1;
                                desc.b.code  = ctr_pkg::ST_TOO_LONG;
                                desc.b.value = shifted;
                                phase_next   = PH_HALT;
                            end else if (shifted == 32'd0) begin
                                desc.word_en = 1'b1;
                                desc.b_en    = 1'b1;
                                desc.b.value = total_reg;
                                if (total_reg != size_reg) begin
                                    desc.b.code = ctr_pkg::ST_SIZE_ERR;
                                    phase_next  = PH_HALT;
                                end else begin
                                    desc.word   = ctr_pkg::WORD_DONE;
                                    desc.b.code = ctr_pkg::ST_FILE_DONE;
                                    phase_next  = PH_HUNT;
                                    pos_next    = 3'd0;
                                end
                            end else begin
                                clen_next  = shifted[23:0];
                                crcr_next  = ~crcc_reg;
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        desc.a_en   = 1'b1;
                        desc.a.kind = ctr_pkg::KIND_DATA;
                        desc.a.data = rx_byte;
                        crcr_next   = ctr_pkg::crc_byte(crcr_reg, rx_byte);
                        count_next  = cnt_inc;
                        if (cnt_inc >= clen_reg) begin
                            phase_next = PH_CRC;
                            count_next = '0;
                            shift_next = '0;
                            timer_next = '0;
                        end
                    end
                    PH_CRC: begin
                        shift_next = shifted;
                        count_next = cnt_inc;
                        if (cnt_inc >= 24'd4) begin
                            phase_next   = PH_LEN;
                            count_next   = '0;
                            shift_next   = '0;
                            timer_next   = '0;
                            desc.b_en    = 1'b1;
                            desc.b.value = {8'd0, clen_reg};
                            desc.b.code  = ctr_pkg::ST_CHUNK_OK;
                            if (crcen_reg && crc_fin != shifted) begin
                                desc.word_en = 1'b1;
                                desc.word    = ctr_pkg::WORD_FAIL;
                                desc.b.code  = ctr_pkg::ST_CHUNK_FAIL;
                            end else begin
                                if (crcen_reg) begin
                                    desc.word_en = 1'b1;
                                    desc.word    = ctr_pkg::WORD_PASS;
                                    crcc_next    = crc_fin;
                                end
                                total_next = total_reg + {8'd0, clen_reg};
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // State and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            pos_reg   <= '0;
            count_reg <= '0;
            timer_reg <= '0;
            shift_reg <= '0;
            size_reg  <= '0;
            clen_reg  <= '0;
            total_reg <= '0;
            crcc_reg  <= '0;
            crcr_reg  <= '1;
            tmo_reg   <= ctr_pkg::TIMEOUT_RESET;
            crcen_reg <= 1'b1;
            maxc_reg  <= ctr_pkg::MAX_CHUNK_RESET;
        end else begin
            if (in_fire) begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                count_reg <= count_next;
                timer_reg <= timer_next;
                shift_reg <= shift_next;
                size_reg  <= size_next;
                clen_reg  <= clen_next;
                total_reg <= total_next;
                crcc_reg  <= crcc_next;
                crcr_reg  <= crcr_next;
            end
            if (cfg_we) begin
                case (cfg_index)
                    ctr_pkg::CFG_TIMEOUT:   tmo_reg   <= cfg_data[23:0];
                    ctr_pkg::CFG_CRC_EN:    crcen_reg <= cfg_data[0];
                    ctr_pkg::CFG_MAX_CHUNK: maxc_reg  <= cfg_data[23:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== rtl/core/ctr_emit.sv =====
module ctr_emit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           load,
    input  ctr_pkg::desc_t desc_in,
    output logic           can_load,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [1:0]     m_out_kind,
    output logic [7:0]     m_out_byte,
    output logic [3:0]     m_status_code,
    output logic [31:0]    m_status_value,
    output logic           m_last
);

    ctr_pkg::desc_t desc_reg;
    logic           valid_reg;
    logic [2:0]     pos_reg;
    logic [5:0]     mask_reg;
    logic [5:0]     mask_in;
    logic [5:0]     above;
    logic [2:0]     pos_adv;
    logic [2:0]     pos_first;
    ctr_pkg::item_t cur;

    // Result slots: four reply bytes, item a, item b
    assign mask_in = {desc_in.b_en, desc_in.a_en, {4{desc_in.word_en}}};
    assign above   = mask_reg & ~((6'd2 << pos_reg) - 6'd1);
    assign m_last  = (above == 6'd0);
    assign can_load = !valid_reg || (m_ready && m_last);
    assign m_valid  = valid_reg;

    // Lowest occupied slot
    always_comb begin
        pos_adv   = 3'd0;
        pos_first = 3'd0;
        for (int i = 5; i >= 0; i--) begin
            if (above[i])   pos_adv   = 3'(i);
            if (mask_in[i]) pos_first = 3'(i);
        end
    end

    // Output field selection
    always_comb begin
        cur = '0;
        if (pos_reg == 3'd5) begin
            cur = desc_reg.b;
        end else if (pos_reg == 3'd4) begin
            cur = desc_reg.a;
        end else begin
            cur.kind = ctr_pkg::KIND_TX;
            cur.data = ctr_pkg::word_byte(desc_reg.word, pos_reg[1:0]);
        end
    end

    assign m_out_kind     = cur.kind;
    assign m_out_byte     = cur.data;
    assign m_status_code  = cur.code;
    assign m_status_value = cur.value;

    // Slot sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
            mask_reg  <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            pos_reg   <= pos_first;
            mask_reg  <= mask_in;
        end else if (valid_reg && m_ready) begin
            if (m_last) begin
                valid_reg <= 1'b0;
            end else begin
                pos_reg <= pos_adv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) desc_reg <= desc_in;
    end

endmodule

// ===== rtl/core/chunked_transfer_receiver.sv =====
// Chunked file-transfer receiver. Each input transaction (received byte, tick or
// cancel) is decoded and produces zero to five result transactions: reply bytes
// on kind 0, header and payload bytes on kinds 1 and 2, and a status event on
// kind 3, with m_last on the final one. While m_ready is high, a transaction
// with one result is taken every cycle; otherwise the next input is taken in
// the cycle its last result leaves. After a timeout, a length or size error, a
// cancel or a close marker the block ignores all input until reset. Configuration
// writes are always ready and must only be issued while the block is idle.
`include "chunked_transfer_receiver_defines.svh"

module chunked_transfer_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_out_kind,
    output logic [7:0]  m_out_byte,
    output logic [3:0]  m_status_code,
    output logic [31:0] m_status_value,
    output logic        m_last
);

    ctr_pkg::desc_t desc;
    logic           desc_any;
    logic           in_fire;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_valid && s_ready;

    ctr_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_fire   (in_fire),
        .req_type  (s_req_type),
        .rx_byte   (s_rx_byte),
        .desc_any  (desc_any),
        .desc      (desc)
    );

    ctr_emit u_emit (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (in_fire && desc_any),
        .desc_in        (desc),
        .can_load       (s_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_kind     (m_out_kind),
        .m_out_byte     (m_out_byte),
        .m_status_code  (m_status_code),
        .m_status_value (m_status_value),
        .m_last         (m_last)
    );

    `CTR_ASSERT_IMP(a_byte_no_status, aclk, aresetn, m_valid && m_out_kind != ctr_pkg::KIND_STATUS, m_status_code == 4'd0 && m_status_value == 32'd0, "byte result carries status")
    `CTR_ASSERT_IMP(a_status_no_byte, aclk, aresetn, m_valid && m_out_kind == ctr_pkg::KIND_STATUS, m_out_byte == 8'd0, "status result carries a byte")
    `CTR_ASSERT_IMP(a_status_is_last, aclk, aresetn, m_valid && m_out_kind == ctr_pkg::KIND_STATUS, m_last, "status event not final")
    `CTR_ASSERT_IMP(a_busy_blocks, aclk, aresetn, m_valid && !m_last, !s_ready, "input taken mid sequence")
    `CTR_ASSERT_NEXT(a_hold_result, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_kind) && $stable(m_out_byte) && $stable(m_status_code) && $stable(m_last), "result changed while stalled")

endmodule
